[rtl/rfp_pkg.sv]
// Shared types, constants and the sine table builder for the radial falloff profile block.
// Used by every module in this folder; depends on nothing else.
package rfp_pkg;

    localparam int OFFSET_WIDTH     = 16;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SIZE_W           = 13;
    localparam int MODE_W           = 2;
    localparam int INDEX_W          = 2;
    localparam int D_W              = 16;
    localparam int WEIGHT_W         = 17;
    localparam int ONE_Q14          = 16384;
    localparam int S_W              = 2 * OFFSET_WIDTH;
    localparam int V_W              = S_W + 22;
    localparam int ROOT_W           = V_W / 2;
    localparam int REM_W            = ROOT_W + 2;
    localparam int DREM_W           = SIZE_W + 1;
    localparam int TAB_W            = 15;
    localparam int TIDX_W           = $clog2(SINE_TABLE_DEPTH + 1);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Register indexes of the configuration port.
    localparam logic [INDEX_W-1:0] REG_BRUSH_SIZE   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FALLOFF_MODE = 2'd1;

    // Falloff modes.
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CURVE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

    typedef struct packed {
        logic signed [OFFSET_WIDTH-1:0] offset_x;
        logic signed [OFFSET_WIDTH-1:0] offset_y;
    } item_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       distance_saturated;
    } result_t;

    // Control bits that travel with every item along the chain.
    typedef struct packed {
        logic valid;
        logic sat;
    } ctl_t;

    // Quarter-wave sine entry in Q14, evaluated at elaboration by a Q30 Taylor series.
    function automatic logic [TAB_W-1:0] sin_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned mag;
        longint          sum;
        longint unsigned q;
        x   = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        mag = x;
        sum = longint'(x);
        for (int n = 1; n <= 10; n++)
        begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            mag = mag / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
                sum = sum - longint'(mag);
            else
                sum = sum + longint'(mag);
        end
        if (sum < 0)
            sum = 0;
        q = (longint'(sum) + 64'd32768) >> 16;
        if (q > 64'(ONE_Q14))
            q = 64'(ONE_Q14);
        return q[TAB_W-1:0];
    endfunction

endpackage

[rtl/radial_falloff_profile_top.sv]
// Radial falloff profile: offset magnitude, square root chain, divider chain and shaper.
// The item passes 2 front stages, 27 square root cells,
// 16 divider cells and 3 shaper stages. One item is taken every cycle; busy stays low.
// Results cannot be stalled: done is high for exactly one cycle per item.
// Reset clears the item pipeline and sets brush_size to 16 and falloff_mode to linear.
module radial_falloff_profile_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rfp_pkg::item_t                  item,
    output logic                            done,
    output rfp_pkg::result_t                result,
    input  logic                            wr_en,
    input  logic [rfp_pkg::INDEX_W-1:0]     wr_index,
    input  logic [rfp_pkg::SIZE_W-1:0]      wr_data
);

    localparam int OW     = rfp_pkg::OFFSET_WIDTH;
    localparam int RW     = rfp_pkg::ROOT_W;
    localparam int DW     = rfp_pkg::D_W;
    localparam int SQ_W   = 2 * rfp_pkg::SIZE_W;
    localparam int CMP_W  = 2 * rfp_pkg::SIZE_W + 10;
    localparam int LATENCY = 2 + RW + DW + 3;

    // Configuration registers.
    logic [rfp_pkg::SIZE_W-1:0]     brush_size_reg;
    logic [rfp_pkg::MODE_W-1:0]     falloff_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_size_reg   <= 13'd16;
            falloff_mode_reg <= rfp_pkg::MODE_LINEAR;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rfp_pkg::REG_BRUSH_SIZE:   brush_size_reg   <= wr_data;
                rfp_pkg::REG_FALLOFF_MODE: falloff_mode_reg <= wr_data[rfp_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Front stage one: offset magnitudes.
    logic                 m_valid_reg;
    logic [OW-1:0]        mx_reg;
    logic [OW-1:0]        my_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        mx_reg <= item.offset_x[OW-1] ? OW'(-item.offset_x) : OW'(item.offset_x);
        my_reg <= item.offset_y[OW-1] ? OW'(-item.offset_y) : OW'(item.offset_y);
    end

    // Front stage two: sum of squares and the saturation test against the squared size.
    rfp_pkg::ctl_t             s_ctl_reg;
    logic [rfp_pkg::S_W-1:0]   s_reg;
    logic [rfp_pkg::S_W-1:0]   sum_sq;
    logic [SQ_W-1:0]           size_sq;
    logic                      sat_next;

    always_comb
    begin
        sum_sq   = (rfp_pkg::S_W'(mx_reg) * rfp_pkg::S_W'(mx_reg))
                 + (rfp_pkg::S_W'(my_reg) * rfp_pkg::S_W'(my_reg));
        size_sq  = SQ_W'(brush_size_reg) * SQ_W'(brush_size_reg);
        sat_next = (brush_size_reg == '0)
                || (CMP_W'(sum_sq) >= {size_sq, 10'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_ctl_reg <= '0;
        else
        begin
            s_ctl_reg.valid <= m_valid_reg;
            s_ctl_reg.sat   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= sum_sq;
    end

    // Square root chain over sum_sq * 2^22.
    rfp_pkg::ctl_t               sq_ctl  [0:RW];
    logic [rfp_pkg::V_W-1:0]     sq_v    [0:RW];
    logic [rfp_pkg::REM_W-1:0]   sq_rem  [0:RW];
    logic [RW-1:0]               sq_root [0:RW];

    assign sq_ctl[0]  = s_ctl_reg;
    assign sq_v[0]    = {s_reg, 22'b0};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        rfp_sqrt_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (sq_ctl[k]),
            .radicand     (sq_v[k]),
            .rem          (sq_rem[k]),
            .root         (sq_root[k]),
            .ctl_out      (sq_ctl[k+1]),
            .radicand_out (sq_v[k+1]),
            .rem_out      (sq_rem[k+1]),
            .root_out     (sq_root[k+1])
        );
    end

    // Divider chain: the root's top bits are already below the brush size.
    rfp_pkg::ctl_t                dv_ctl  [0:DW];
    logic [rfp_pkg::DREM_W-1:0]   dv_rem  [0:DW];
    logic [DW-1:0]                dv_quot [0:DW];

    assign dv_ctl[0]  = sq_ctl[RW];
    assign dv_rem[0]  = rfp_pkg::DREM_W'(sq_root[RW][RW-1:DW]);
    assign dv_quot[0] = sq_root[RW][DW-1:0];

    for (genvar k = 0; k < DW; k++)
    begin : g_div
        rfp_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (brush_size_reg),
            .ctl      (dv_ctl[k]),
            .rem      (dv_rem[k]),
            .quot     (dv_quot[k]),
            .ctl_out  (dv_ctl[k+1]),
            .rem_out  (dv_rem[k+1]),
            .quot_out (dv_quot[k+1])
        );
    end

    // Saturated items take the largest distance code.
    logic [DW-1:0] norm_dist;

    assign norm_dist = dv_ctl[DW].sat ? '1 : dv_quot[DW];

    rfp_shaper u_shaper (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (falloff_mode_reg),
        .ctl       (dv_ctl[DW]),
        .norm_dist (norm_dist),
        .done      (done),
        .result    (result)
    );

    // Every accepted item leaves exactly after the pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item did not leave after the pipeline latency");

    // A saturated linear result carries the largest distance code.
    a_sat_linear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.distance_saturated && falloff_mode_reg == rfp_pkg::MODE_LINEAR)
        |-> (result.weight == 17'sd65535))
        else $error("saturated linear weight is wrong");

    // The zero mode never gives a weight.
    a_mode_none: assert property (@(posedge clk) disable iff (!rst_n)
        (done && falloff_mode_reg == rfp_pkg::MODE_NONE) |-> (result.weight == '0))
        else $error("zero mode gave a weight");

    // A zero brush size always saturates.
    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (done && brush_size_reg == '0) |-> result.distance_saturated)
        else $error("zero brush size did not saturate");

endmodule

[rtl/rfp_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per cycle.
// Depends on rfp_pkg.
module rfp_sqrt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rfp_pkg::ctl_t                 ctl,
    input  logic [rfp_pkg::V_W-1:0]       radicand,
    input  logic [rfp_pkg::REM_W-1:0]     rem,
    input  logic [rfp_pkg::ROOT_W-1:0]    root,
    output rfp_pkg::ctl_t                 ctl_out,
    output logic [rfp_pkg::V_W-1:0]       radicand_out,
    output logic [rfp_pkg::REM_W-1:0]     rem_out,
    output logic [rfp_pkg::ROOT_W-1:0]    root_out
);

    rfp_pkg::ctl_t                 ctl_reg;
    logic [rfp_pkg::V_W-1:0]       radicand_reg;
    logic [rfp_pkg::REM_W-1:0]     rem_reg;
    logic [rfp_pkg::ROOT_W-1:0]    root_reg;
    logic [rfp_pkg::REM_W-1:0]     rem_sh;
    logic [rfp_pkg::REM_W-1:0]     trial;
    logic                          take;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb
    begin
        rem_sh = {rem[rfp_pkg::ROOT_W-1:0], radicand[rfp_pkg::V_W-1 -: 2]};
        trial  = {root, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        radicand_reg <= {radicand[rfp_pkg::V_W-3:0], 2'b00};
        rem_reg      <= take ? (rem_sh - trial) : rem_sh;
        root_reg     <= {root[rfp_pkg::ROOT_W-2:0], take};
    end

    assign ctl_out      = ctl_reg;
    assign radicand_out = radicand_reg;
    assign rem_out      = rem_reg;
    assign root_out     = root_reg;

endmodule

[rtl/rfp_div_cell.sv]
// One cell of the divider chain: settles one quotient bit of root / brush size per cycle.
// Depends on rfp_pkg.
module rfp_div_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rfp_pkg::SIZE_W-1:0]    divisor,
    input  rfp_pkg::ctl_t                 ctl,
    input  logic [rfp_pkg::DREM_W-1:0]    rem,
    input  logic [rfp_pkg::D_W-1:0]       quot,
    output rfp_pkg::ctl_t                 ctl_out,
    output logic [rfp_pkg::DREM_W-1:0]    rem_out,
    output logic [rfp_pkg::D_W-1:0]       quot_out
);

    rfp_pkg::ctl_t                 ctl_reg;
    logic [rfp_pkg::DREM_W-1:0]    rem_reg;
    logic [rfp_pkg::D_W-1:0]       quot_reg;
    logic [rfp_pkg::DREM_W-1:0]    rem_sh;
    logic [rfp_pkg::DREM_W-1:0]    dvs;
    logic                          take;

    // Shift in the next dividend bit, which leaves the top of the quotient word.
    always_comb
    begin
        rem_sh = {rem[rfp_pkg::DREM_W-2:0], quot[rfp_pkg::D_W-1]};
        dvs    = {1'b0, divisor};
        take   = (rem_sh >= dvs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= take ? (rem_sh - dvs) : rem_sh;
        quot_reg <= {quot[rfp_pkg::D_W-2:0], take};
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign quot_out = quot_reg;

endmodule

[rtl/rfp_shaper.sv]
// Turns the normalised distance into the weight of the selected falloff mode.
// Holds the quarter-wave sine table; depends on rfp_pkg.
module rfp_shaper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rfp_pkg::MODE_W-1:0]    mode,
    input  rfp_pkg::ctl_t                 ctl,
    input  logic [rfp_pkg::D_W-1:0]       norm_dist,
    output logic                          done,
    output rfp_pkg::result_t              result
);

    localparam int POS_W = 15 + $clog2(rfp_pkg::SINE_TABLE_DEPTH + 1);

    logic [rfp_pkg::TAB_W-1:0] sin_tab [0:rfp_pkg::SINE_TABLE_DEPTH];

    // Constant table, one entry per sample of the quarter wave.
    for (genvar gi = 0; gi <= rfp_pkg::SINE_TABLE_DEPTH; gi++)
    begin : g_tab
        localparam logic [rfp_pkg::TAB_W-1:0] ENTRY = rfp_pkg::sin_entry(gi);
        assign sin_tab[gi] = ENTRY;
    end

    // Stage A: phase, quadrant folding and table position.
    logic                          a_valid_reg;
    logic                          a_sat_reg;
    logic                          a_neg_reg;
    logic [rfp_pkg::D_W-1:0]       a_dist_reg;
    logic [rfp_pkg::TIDX_W-1:0]    a_idx_reg;
    logic [rfp_pkg::TIDX_W-1:0]    a_idx1_reg;
    logic [13:0]                   a_frac_reg;
    logic [rfp_pkg::D_W-1:0]       phase;
    logic [14:0]                   fold;
    logic [POS_W-1:0]              pos;
    logic [POS_W-15:0]             pos_idx;
    logic [rfp_pkg::TIDX_W-1:0]    idx_next;
    logic [rfp_pkg::TIDX_W-1:0]    idx1_next;
    logic [13:0]                   frac_next;

    always_comb
    begin
        phase = (mode == rfp_pkg::MODE_CURVE) ? (norm_dist + 16'(rfp_pkg::ONE_Q14))
                                              : norm_dist;
        fold  = phase[14] ? (15'(rfp_pkg::ONE_Q14) - {1'b0, phase[13:0]})
                          : {1'b0, phase[13:0]};
        pos     = POS_W'(fold) * POS_W'(rfp_pkg::SINE_TABLE_DEPTH);
        pos_idx = pos[POS_W-1:14];
        if (pos_idx >= (POS_W-14)'(rfp_pkg::SINE_TABLE_DEPTH))
        begin
            idx_next  = rfp_pkg::TIDX_W'(rfp_pkg::SINE_TABLE_DEPTH);
            idx1_next = rfp_pkg::TIDX_W'(rfp_pkg::SINE_TABLE_DEPTH);
            frac_next = '0;
        end
        else
        begin
            idx_next  = pos_idx[rfp_pkg::TIDX_W-1:0];
            idx1_next = pos_idx[rfp_pkg::TIDX_W-1:0] + 1'b1;
            frac_next = pos[13:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        a_sat_reg  <= ctl.sat;
        a_neg_reg  <= phase[15];
        a_dist_reg <= norm_dist;
        a_idx_reg  <= idx_next;
        a_idx1_reg <= idx1_next;
        a_frac_reg <= frac_next;
    end

    // Stage B: table look-up and linear interpolation.
    logic                          b_valid_reg;
    logic                          b_sat_reg;
    logic                          b_neg_reg;
    logic [rfp_pkg::D_W-1:0]       b_dist_reg;
    logic [rfp_pkg::TAB_W-1:0]     b_mag_reg;
    logic [rfp_pkg::TAB_W-1:0]     tab_a;
    logic [rfp_pkg::TAB_W-1:0]     tab_b;
    logic [28:0]                   prod;

    always_comb
    begin
        tab_a = sin_tab[a_idx_reg];
        tab_b = sin_tab[a_idx1_reg];
        if (tab_b < tab_a)
            tab_b = tab_a;
        prod = 29'(tab_b - tab_a) * 29'(a_frac_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_sat_reg  <= a_sat_reg;
        b_neg_reg  <= a_neg_reg;
        b_dist_reg <= a_dist_reg;
        b_mag_reg  <= tab_a + prod[28:14];
    end

    // Stage C: sign, mode selection and the output register.
    logic                                done_reg;
    rfp_pkg::result_t                    result_reg;
    logic signed [rfp_pkg::WEIGHT_W-1:0] sin_val;
    logic signed [rfp_pkg::WEIGHT_W-1:0] weight_next;

    always_comb
    begin
        sin_val = b_neg_reg ? -$signed({2'b00, b_mag_reg}) : $signed({2'b00, b_mag_reg});
        case (mode)
            rfp_pkg::MODE_LINEAR:  weight_next = $signed({1'b0, b_dist_reg});
            rfp_pkg::MODE_STRETCH: weight_next = sin_val;
            rfp_pkg::MODE_CURVE:
                weight_next = rfp_pkg::WEIGHT_W'(rfp_pkg::ONE_Q14) - sin_val;
            default:               weight_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg.weight             <= weight_next;
        result_reg.distance_saturated <= b_sat_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
